[sv/tmi_pkg.sv]
// Package with the shared constants and types of the triclinic minimum-image block.
`timescale 1ns / 1ps
package tmi_pkg;
    // Default datapath format.
    localparam int COORD_WIDTH = 21;
    localparam int FRAC_BITS   = 14;

    // Configuration port.
    localparam int REG_WIDTH   = 63;
    localparam int NUM_REGS    = 6;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_BOX_A = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BOX_B = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BOX_C = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_A = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_B = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_C = 3'd5;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Box-vector shift codes, two-bit two's complement.
    localparam logic [1:0] SHIFT_NEG  = 2'b11;
    localparam logic [1:0] SHIFT_ZERO = 2'b00;
    localparam logic [1:0] SHIFT_POS  = 2'b01;

    // Fill state of the queue as seen by its neighbors.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;
endpackage

[sv/tmi_in_if.sv]
// Input channel: one displacement word per handshake.
`timescale 1ns / 1ps
interface tmi_in_if #(
    parameter int COORD_WIDTH = tmi_pkg::COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] disp_x;
    logic signed [COORD_WIDTH-1:0] disp_y;
    logic signed [COORD_WIDTH-1:0] disp_z;

    modport source (output valid, disp_x, disp_y, disp_z, input ready);
    modport sink   (input valid, disp_x, disp_y, disp_z, output ready);
endinterface

[sv/tmi_out_if.sv]
// Output channel: one minimum-image word per handshake.
`timescale 1ns / 1ps
interface tmi_out_if #(
    parameter int COORD_WIDTH = tmi_pkg::COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] image_x;
    logic signed [COORD_WIDTH-1:0] image_y;
    logic signed [COORD_WIDTH-1:0] image_z;
    logic [2*COORD_WIDTH-1:0]      length_squared;

    modport source (output valid, image_x, image_y, image_z, length_squared, input ready);
    modport sink   (input valid, image_x, image_y, image_z, length_squared, output ready);
endinterface

[sv/tmi_front.sv]
// Front end: accepts displacements and reduces them to wrapped fractional coordinates.
`timescale 1ns / 1ps
module tmi_front #(
    parameter int COORD_WIDTH = tmi_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = tmi_pkg::FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tmi_in_if.sink                              i_disp,
    input  logic signed [COORD_WIDTH-1:0]       i_inv [3][3],
    input  tmi_pkg::t_queue_status              i_q_status,
    output logic                                o_push,
    output logic signed [COORD_WIDTH-3:0]       o_frac [3]
);
    localparam int IFB  = COORD_WIDTH - 3;
    localparam int FW   = IFB + 1;
    localparam int PW   = 2 * COORD_WIDTH;
    localparam int AW   = PW + 2;
    localparam logic [AW:0] HALF = (AW + 1)'(1) << (FRAC_BITS - 1);

    logic                 r_v1, r_v2;
    logic signed [PW-1:0] r_prod [3][3];
    logic signed [FW-1:0] r_frac [3];
    logic signed [FW-1:0] n_frac [3];
    logic signed [COORD_WIDTH-1:0] w_disp [3];
    logic                 w_en;

    assign w_disp[0] = i_disp.disp_x;
    assign w_disp[1] = i_disp.disp_y;
    assign w_disp[2] = i_disp.disp_z;

    // The front holds only when its last stage cannot hand its word to the queue.
    assign w_en         = !(r_v2 && i_q_status.full);
    assign i_disp.ready = w_en;
    assign o_push       = r_v2 && !i_q_status.full;
    assign o_frac       = r_frac;

    // Sum of products, rounding to the inverse format and removal of the nearest integer.
    for (genvar i = 0; i < 3; i++) begin : g_frac
        logic signed [AW-1:0]  w_acc;
        logic [AW-1:0]         w_mag;
        logic [AW:0]           w_rnd;
        logic [IFB-1:0]        w_low;
        logic signed [FW-1:0]  w_rs;

        always_comb begin
            w_acc = AW'(r_prod[0][i]) + AW'(r_prod[1][i]) + AW'(r_prod[2][i]);
            w_mag = w_acc[AW-1] ? AW'(-w_acc) : w_acc;
            w_rnd = {1'b0, w_mag} + HALF;
            w_low = w_rnd[FRAC_BITS +: IFB];
            // The low bits read as signed give the remainder in [-1/2, 1/2).
            w_rs  = FW'($signed(w_low));
            n_frac[i] = w_acc[AW-1] ? -w_rs : w_rs;
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_disp.valid;
            r_v2 <= r_v1;
        end
    end

    // Stage payloads: products, then fractional coordinates.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r_prod[j][i] <= PW'(i_inv[j][i]) * PW'(w_disp[j]);
                end
            end
            r_frac <= n_frac;
        end
    end
endmodule

[sv/tmi_queue.sv]
// Short queue of fractional-coordinate words between the front and the back.
`timescale 1ns / 1ps
module tmi_queue #(
    parameter int FW    = tmi_pkg::COORD_WIDTH - 2,
    parameter int DEPTH = tmi_pkg::QUEUE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic signed [FW-1:0]    i_frac [3],
    input  logic                    i_pop,
    output logic signed [FW-1:0]    o_frac [3],
    output tmi_pkg::t_queue_status  o_status
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [3*FW-1:0]  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;

    assign o_frac[0] = $signed(r_mem[r_rd][0 +: FW]);
    assign o_frac[1] = $signed(r_mem[r_rd][FW +: FW]);
    assign o_frac[2] = $signed(r_mem[r_rd][2*FW +: FW]);

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= {i_frac[2], i_frac[1], i_frac[0]};
        end
    end
endmodule

[sv/tmi_back.sv]
// Back end: maps back to Cartesian, searches the 27 neighbor shifts and saturates the result.
`timescale 1ns / 1ps
module tmi_back #(
    parameter int COORD_WIDTH = tmi_pkg::COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [COORD_WIDTH-1:0] i_box [3][3],
    input  logic signed [COORD_WIDTH-3:0] i_frac [3],
    input  tmi_pkg::t_queue_status        i_q_status,
    output logic                          o_pop,
    tmi_out_if.source                     o_image
);
    localparam int W    = COORD_WIDTH;
    localparam int IFB  = W - 3;
    localparam int FW   = W - 2;
    localparam int BPW  = W + FW;
    localparam int BAW  = BPW + 2;
    localparam int CW   = BAW + 2 - IFB;
    localparam int CDW  = CW + 2;
    localparam int SQW  = 2 * CDW;
    localparam int LW   = SQW + 2;
    localparam int NS   = 10;
    localparam logic [BAW:0] HALF = (BAW + 1)'(1) << (IFB - 1);
    localparam logic signed [CDW-1:0] SAT_HI = CDW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [CDW-1:0] SAT_LO = -SAT_HI - CDW'(1);

    logic [NS-1:0]         r_v;
    logic                  w_en;
    logic signed [BPW-1:0] r_bp [3][3];
    logic signed [CW-1:0]  r_c [6][3];
    logic signed [CW-1:0]  n_c [3];
    logic [SQW-1:0]        r_sq [27][3];
    logic [SQW-1:0]        n_sq [27][3];
    logic [LW-1:0]         r_len [27];
    logic [LW-1:0]         r_m5_len [9];
    logic [5:0]            r_m5_k [9];
    logic [LW-1:0]         n_m5_len [9];
    logic [5:0]            n_m5_k [9];
    logic [LW-1:0]         r_m6_len [3];
    logic [5:0]            r_m6_k [3];
    logic [LW-1:0]         n_m6_len [3];
    logic [5:0]            n_m6_k [3];
    logic [5:0]            r_k7, n_k7;
    logic signed [W-1:0]   r_img8 [3];
    logic signed [W-1:0]   n_img8 [3];
    logic signed [W-1:0]   r_img9 [3];
    logic [2*W-1:0]        r_isq [3];
    logic signed [W-1:0]   r_out_img [3];
    logic [2*W-1:0]        r_out_len;

    // Index of the smallest of three lengths; a later one wins only if strictly shorter.
    function automatic logic [1:0] pick3(input logic [LW-1:0] a, input logic [LW-1:0] b,
                                         input logic [LW-1:0] c);
        logic [1:0]    p;
        logic [LW-1:0] m;
        p = 2'd0;
        m = a;
        if (b < m) begin
            p = 2'd1;
            m = b;
        end
        if (c < m) begin
            p = 2'd2;
        end
        return p;
    endfunction

    // One box-vector component times a shift code.
    function automatic logic signed [CDW-1:0] kbox(input logic [1:0] k,
                                                   input logic signed [W-1:0] b);
        logic signed [CDW-1:0] v;
        case (k)
            tmi_pkg::SHIFT_POS:  v = CDW'(b);
            tmi_pkg::SHIFT_NEG:  v = -CDW'(b);
            tmi_pkg::SHIFT_ZERO: v = '0;
            default:             v = '0;
        endcase
        return v;
    endfunction

    // The whole back end advances whenever the output register is free or being taken.
    assign w_en  = !r_v[NS-1] || o_image.ready;
    assign o_pop = w_en && !i_q_status.empty;

    assign o_image.valid          = r_v[NS-1];
    assign o_image.image_x        = r_out_img[0];
    assign o_image.image_y        = r_out_img[1];
    assign o_image.image_z        = r_out_img[2];
    assign o_image.length_squared = r_out_len;

    // Cartesian center image, rounded to the coordinate format.
    for (genvar i = 0; i < 3; i++) begin : g_center
        logic signed [BAW-1:0] w_acc;
        logic [BAW-1:0]        w_mag;
        logic [BAW:0]          w_rnd;
        logic signed [CW-1:0]  w_m;
        always_comb begin
            w_acc = BAW'(r_bp[0][i]) + BAW'(r_bp[1][i]) + BAW'(r_bp[2][i]);
            w_mag = w_acc[BAW-1] ? BAW'(-w_acc) : w_acc;
            w_rnd = {1'b0, w_mag} + HALF;
            w_m   = CW'(w_rnd[BAW:IFB]);
            n_c[i] = w_acc[BAW-1] ? -w_m : w_m;
        end
    end

    // Squared components of all 27 shifted candidates.
    for (genvar a = 0; a < 3; a++) begin : g_ka
        for (genvar b = 0; b < 3; b++) begin : g_kb
            for (genvar c = 0; c < 3; c++) begin : g_kc
                localparam int N = a * 9 + b * 3 + c;
                for (genvar i = 0; i < 3; i++) begin : g_axis
                    logic signed [CDW-1:0] w_cand;
                    logic signed [SQW-1:0] w_sq;
                    always_comb begin
                        w_cand = CDW'(r_c[0][i]) + kbox(2'(a - 1), i_box[0][i])
                                 + kbox(2'(b - 1), i_box[1][i])
                                 + kbox(2'(c - 1), i_box[2][i]);
                        w_sq   = SQW'(w_cand) * SQW'(w_cand);
                        n_sq[N][i] = $unsigned(w_sq);
                    end
                end
            end
        end
    end

    // First reduction: groups of three consecutive candidates.
    for (genvar g = 0; g < 9; g++) begin : g_min5
        localparam logic [3:0] KHI = {2'(g / 3 - 1), 2'(g % 3 - 1)};
        logic [1:0] w_p;
        always_comb begin
            w_p = pick3(r_len[3*g], r_len[3*g+1], r_len[3*g+2]);
            case (w_p)
                2'd1:    n_m5_len[g] = r_len[3*g+1];
                2'd2:    n_m5_len[g] = r_len[3*g+2];
                default: n_m5_len[g] = r_len[3*g];
            endcase
            n_m5_k[g] = {KHI, w_p - 2'd1};
        end
    end

    // Second reduction: groups of three winners.
    for (genvar g = 0; g < 3; g++) begin : g_min6
        logic [1:0] w_p;
        always_comb begin
            w_p = pick3(r_m5_len[3*g], r_m5_len[3*g+1], r_m5_len[3*g+2]);
            case (w_p)
                2'd1: begin
                    n_m6_len[g] = r_m5_len[3*g+1];
                    n_m6_k[g]   = r_m5_k[3*g+1];
                end
                2'd2: begin
                    n_m6_len[g] = r_m5_len[3*g+2];
                    n_m6_k[g]   = r_m5_k[3*g+2];
                end
                default: begin
                    n_m6_len[g] = r_m5_len[3*g];
                    n_m6_k[g]   = r_m5_k[3*g];
                end
            endcase
        end
    end

    // Final reduction picks the shift of the shortest image.
    always_comb begin
        case (pick3(r_m6_len[0], r_m6_len[1], r_m6_len[2]))
            2'd1:    n_k7 = r_m6_k[1];
            2'd2:    n_k7 = r_m6_k[2];
            default: n_k7 = r_m6_k[0];
        endcase
    end

    // Rebuild the chosen image and saturate it to the coordinate width.
    for (genvar i = 0; i < 3; i++) begin : g_sat
        logic signed [CDW-1:0] w_best;
        always_comb begin
            w_best = CDW'(r_c[5][i]) + kbox(r_k7[5:4], i_box[0][i])
                     + kbox(r_k7[3:2], i_box[1][i]) + kbox(r_k7[1:0], i_box[2][i]);
            if (w_best > SAT_HI) begin
                n_img8[i] = W'(SAT_HI);
            end else if (w_best < SAT_LO) begin
                n_img8[i] = W'(SAT_LO);
            end else begin
                n_img8[i] = W'(w_best);
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NS-2:0], !i_q_status.empty};
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r_bp[j][i] <= BPW'(i_box[j][i]) * BPW'(i_frac[j]);
                end
            end
            r_c[0] <= n_c;
            for (int s = 1; s < 6; s++) begin
                r_c[s] <= r_c[s-1];
            end
            r_sq <= n_sq;
            for (int n = 0; n < 27; n++) begin
                r_len[n] <= LW'(r_sq[n][0]) + LW'(r_sq[n][1]) + LW'(r_sq[n][2]);
            end
            r_m5_len <= n_m5_len;
            r_m5_k   <= n_m5_k;
            r_m6_len <= n_m6_len;
            r_m6_k   <= n_m6_k;
            r_k7     <= n_k7;
            r_img8   <= n_img8;
            r_img9   <= r_img8;
            for (int i = 0; i < 3; i++) begin
                r_isq[i] <= $unsigned((2*W)'(r_img8[i]) * (2*W)'(r_img8[i]));
            end
            r_out_img <= r_img9;
            r_out_len <= r_isq[0] + r_isq[1] + r_isq[2];
        end
    end
endmodule

[sv/triclinic_minimum_image.sv]
// Top level of the triclinic minimum-image block: configuration registers and the two halves.
//
// Usage: displacement words arrive on i_disp (valid/ready); each yields exactly one word
// on o_image (valid/ready) carrying the saturated minimum image and its squared length.
// Words leave in the order they arrive. The box vectors and inverse rows are written through
// i_cfg_we / i_cfg_index / i_cfg_data; the user must write them only while no word is in
// flight, which the block does not enforce; an index past the last register is ignored.
// Throughput: one word per cycle when o_image.ready stays high.
// Path from input acceptance to o_image: 2 front stages, the queue and 10 back stages,
// the last of which is the output register.
// When the receiver stalls, the back end holds; the front keeps accepting until the
// four-entry queue is full and its last stage holds a word, then drops i_disp.ready.
// Synchronous reset clears the configuration registers to zero and empties the pipeline and queue.
`timescale 1ns / 1ps
module triclinic_minimum_image #(
    parameter int COORD_WIDTH = tmi_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = tmi_pkg::FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tmi_in_if.sink                              i_disp,
    tmi_out_if.source                           o_image,
    input  logic                                i_cfg_we,
    input  logic [tmi_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [tmi_pkg::REG_WIDTH-1:0]       i_cfg_data
);
    localparam int W     = COORD_WIDTH;
    localparam int PAD_W = 3 * W;
    localparam int FW    = W - 2;

    logic [tmi_pkg::REG_WIDTH-1:0] r_regs [tmi_pkg::NUM_REGS];
    logic signed [W-1:0]           w_box [3][3];
    logic signed [W-1:0]           w_inv [3][3];
    logic signed [FW-1:0]          w_push_frac [3];
    logic signed [FW-1:0]          w_pop_frac [3];
    logic                          w_push, w_pop;
    tmi_pkg::t_queue_status        w_q_status;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < tmi_pkg::NUM_REGS; r++) begin
                r_regs[r] <= '0;
            end
        end else if (i_cfg_we
                     && (i_cfg_index < tmi_pkg::CFG_INDEX_W'(tmi_pkg::NUM_REGS))) begin
            r_regs[i_cfg_index] <= i_cfg_data;
        end
    end

    // Unpack the signed components of each register.
    for (genvar j = 0; j < 3; j++) begin : g_unpack
        logic [PAD_W-1:0] w_box_bits, w_inv_bits;
        assign w_box_bits = PAD_W'(r_regs[tmi_pkg::REG_BOX_A + j]);
        assign w_inv_bits = PAD_W'(r_regs[tmi_pkg::REG_INV_A + j]);
        for (genvar i = 0; i < 3; i++) begin : g_comp
            assign w_box[j][i] = $signed(w_box_bits[i*W +: W]);
            assign w_inv[j][i] = $signed(w_inv_bits[i*W +: W]);
        end
    end

    tmi_front #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_disp    (i_disp),
        .i_inv     (w_inv),
        .i_q_status(w_q_status),
        .o_push    (w_push),
        .o_frac    (w_push_frac)
    );

    tmi_queue #(
        .FW   (FW),
        .DEPTH(tmi_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frac  (w_push_frac),
        .i_pop   (w_pop),
        .o_frac  (w_pop_frac),
        .o_status(w_q_status)
    );

    tmi_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_box     (w_box),
        .i_frac    (w_pop_frac),
        .i_q_status(w_q_status),
        .o_pop     (w_pop),
        .o_image   (o_image)
    );
endmodule
